[hw/rtl/circuit_disconnect_alarm_assert.svh]
// Assertion macros for the checker file cda_checker.sv.
`ifndef CIRCUIT_DISCONNECT_ALARM_ASSERT_SVH
`define CIRCUIT_DISCONNECT_ALARM_ASSERT_SVH

// The consequent is checked in the cycle after the antecedent, outside reset.
`define CDA_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##1 (cons)) \
    else $error("assertion failed");

// The consequent is checked in the cycle after the antecedent, also during reset.
`define CDA_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |-> ##1 (cons)) \
    else $error("assertion failed");

// The expression holds at every edge outside reset.
`define CDA_ASSERT_HOLDS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("assertion failed");

`endif

[hw/rtl/cda_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package cda_pkg;
  localparam int unsigned QW = 24;
  localparam int unsigned SEQ_W = 32;
  localparam int unsigned VB_W = 3;
  localparam int unsigned FLOOR_W = 23;
  localparam int unsigned CONF_W = 4;
  localparam int unsigned PROD_W = 2 * QW;
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned CNT_W = $clog2(DIV_STEPS);
  localparam int unsigned DATA_W = 32;
  localparam int unsigned ADDR_W = 3;

  localparam int unsigned VB_BREATH = 0;
  localparam int unsigned VB_LEAK = 1;
  localparam int unsigned VB_DISC = 2;

  localparam logic signed [QW-1:0] LEAK_LIMIT = 24'sd12800;
  localparam logic signed [QW-1:0] VOLUME_MIN = 24'sd12800;
  localparam logic signed [QW:0] CORR_MAX = 25'sd768;
  localparam logic [9:0] THR_AFTER_HIT = 10'd200;
  localparam logic [9:0] THR_FIRST = 10'd450;
  localparam logic [FLOOR_W-1:0] FLOOR_RESET = 23'd26;
  localparam logic [CONF_W-1:0] CONF_RESET = 4'd3;

  typedef enum logic {
    REG_FLOOR = 1'b0,
    REG_CONFIRM = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic monitoring_ok;
    logic circuit_restored;
    logic [VB_W-1:0] valid_bits;
    logic [SEQ_W-1:0] breath_sequence;
    logic signed [QW-1:0] leak_coefficient;
    logic signed [QW-1:0] machine_insp_volume;
    logic signed [QW-1:0] patient_peak_flow;
    logic signed [QW-1:0] patient_peak_pressure;
    logic signed [QW-1:0] end_insp_flow;
    logic signed [QW-1:0] signed_insp_volume;
    logic signed [QW-1:0] patient_exp_volume;
  } item_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic floor;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;
endpackage
`default_nettype wire

[hw/rtl/cda_if.sv]
`timescale 1ns / 1ps
`default_nettype none
interface cda_in_if;
  logic valid;
  logic ready;
  logic monitoring_ok;
  logic circuit_restored;
  logic [2:0] valid_bits;
  logic [31:0] breath_sequence;
  logic signed [23:0] leak_coefficient;
  logic signed [23:0] machine_insp_volume;
  logic signed [23:0] patient_peak_flow;
  logic signed [23:0] patient_peak_pressure;
  logic signed [23:0] end_insp_flow;
  logic signed [23:0] signed_insp_volume;
  logic signed [23:0] patient_exp_volume;
  modport source(output valid, monitoring_ok, circuit_restored, valid_bits, breath_sequence,
    leak_coefficient, machine_insp_volume, patient_peak_flow, patient_peak_pressure,
    end_insp_flow, signed_insp_volume, patient_exp_volume, input ready);
  modport sink(input valid, monitoring_ok, circuit_restored, valid_bits, breath_sequence,
    leak_coefficient, machine_insp_volume, patient_peak_flow, patient_peak_pressure,
    end_insp_flow, signed_insp_volume, patient_exp_volume, output ready);
endinterface

interface cda_out_if;
  logic valid;
  logic ready;
  logic alarm_active;
  modport source(output valid, alarm_active, input ready);
  modport sink(input valid, alarm_active, output ready);
endinterface
`default_nettype wire

[hw/rtl/cda_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module cda_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  cda_pkg::sts_t   sts,
  output cda_pkg::cmd_t   cmd
);
  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_FLOOR,
    S_COMMIT
  } state_t;

  state_t state;
  logic [cda_pkg::CNT_W-1:0] count;

  localparam logic [cda_pkg::CNT_W-1:0] LastStep = cda_pkg::CNT_W'(cda_pkg::DIV_STEPS - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          count <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          count <= count + 1'b1;
          if (count == LastStep) begin
            state <= S_FLOOR;
          end
        end
        S_FLOOR: begin
          state <= S_COMMIT;
        end
        S_COMMIT: begin
          if (!sts.out_busy) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    cmd.load = in_ready && in_valid;
    cmd.mul = (state == S_MUL);
    cmd.div_step = (state == S_DIV);
    cmd.floor = (state == S_FLOOR);
    cmd.commit = (state == S_COMMIT) && !sts.out_busy;
  end
endmodule
`default_nettype wire

[hw/rtl/cda_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module cda_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  cda_pkg::cmd_t                  cmd,
  output cda_pkg::sts_t                  sts,
  input  cda_pkg::item_t                 item,
  input  logic [cda_pkg::FLOOR_W-1:0]    pressure_floor,
  input  logic [cda_pkg::CONF_W-1:0]     leak_confirm_breaths,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           alarm_active
);
  localparam int unsigned QW = cda_pkg::QW;
  localparam int unsigned PW = cda_pkg::PROD_W;

  cda_pkg::item_t it;
  logic prod_neg;
  logic [PW-1:0] dvd;
  logic [QW-1:0] rem;
  logic signed [QW:0] p_reg;

  logic [cda_pkg::SEQ_W-1:0] last_sequence;
  logic sequence_seen;
  logic [cda_pkg::CONF_W-1:0] leak_run;
  logic prior_breath_detected;
  logic alarm_latch;

  logic signed [PW-1:0] prod;
  logic [QW:0] trial;
  logic [QW:0] trial_diff;
  logic trial_ge;
  logic signed [QW:0] corr;
  logic signed [QW:0] corr_c;
  logic signed [QW+1:0] diff;
  logic signed [QW:0] p_sat;
  logic signed [QW:0] p_fl;

  always_comb begin
    prod = it.end_insp_flow * it.patient_peak_pressure;
    trial = {rem, dvd[PW-1]};
    trial_diff = trial - {1'b0, it.patient_peak_flow};
    trial_ge = trial >= {1'b0, it.patient_peak_flow};
    corr = prod_neg ? -$signed({1'b0, dvd[QW-1:0]}) : $signed({1'b0, dvd[QW-1:0]});
    corr_c = (corr > cda_pkg::CORR_MAX) ? cda_pkg::CORR_MAX : corr;
    diff = (QW+2)'(it.patient_peak_pressure) - (QW+2)'(corr_c);
    if (diff > (QW+2)'(signed'(24'sh7FFFFF))) begin
      p_sat = 25'sh7FFFFF;
    end else if (diff < (QW+2)'(signed'(24'sh800000))) begin
      p_sat = -25'sh800000;
    end else begin
      p_sat = diff[QW:0];
    end
    p_fl = (p_sat < $signed({2'b00, pressure_floor})) ? $signed({2'b00, pressure_floor}) : p_sat;
  end

  logic gap;
  logic prior_base;
  logic [cda_pkg::CONF_W-1:0] run_base;
  logic [cda_pkg::CONF_W-1:0] run_new;
  logic leak_hi;
  logic [9:0] thr;
  logic signed [QW+10:0] thr_p;
  logic res_ok;
  logic imp;
  logic det;
  logic latch_new;

  always_comb begin
    gap = sequence_seen && ((it.breath_sequence - last_sequence) != 32'd1);
    prior_base = gap ? 1'b0 : prior_breath_detected;
    run_base = gap ? '0 : leak_run;
    leak_hi = it.valid_bits[cda_pkg::VB_LEAK] && (it.leak_coefficient > cda_pkg::LEAK_LIMIT);
    if (!leak_hi) begin
      run_new = '0;
    end else if (run_base < leak_confirm_breaths) begin
      run_new = run_base + 1'b1;
    end else begin
      run_new = run_base;
    end
    thr = prior_base ? cda_pkg::THR_AFTER_HIT : cda_pkg::THR_FIRST;
    thr_p = $signed({1'b0, thr}) * p_reg;
    res_ok = (it.patient_peak_pressure > 0) &&
      (($signed(31'(it.patient_peak_pressure)) * 31'sd60) <
       ($signed(31'(it.patient_peak_flow)) * 31'sd10));
    imp = it.valid_bits[cda_pkg::VB_DISC] && (it.machine_insp_volume > cda_pkg::VOLUME_MIN) &&
      (it.patient_peak_flow > 0) && res_ok;
    det = imp && ((QW+11)'(it.signed_insp_volume) > thr_p) &&
      ((($signed(27'(it.patient_exp_volume))) <<< 3) < 27'(it.machine_insp_volume)) &&
      (((26'(it.signed_insp_volume) - 26'(it.machine_insp_volume)) <<< 1) <
       26'(it.machine_insp_volume));
    latch_new = (det && prior_base) || (run_new >= leak_confirm_breaths);
    sts.out_busy = out_valid;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      it <= item;
    end
    if (cmd.mul) begin
      prod_neg <= prod[PW-1];
      dvd <= prod[PW-1] ? PW'(-prod) : PW'(prod);
      rem <= '0;
    end
    if (cmd.div_step) begin
      rem <= trial_ge ? trial_diff[QW-1:0] : trial[QW-1:0];
      dvd <= {dvd[PW-2:0], trial_ge};
    end
    if (cmd.floor) begin
      p_reg <= p_fl;
    end
    if (cmd.commit) begin
      alarm_active <= 1'b0;
      if (it.monitoring_ok && !it.circuit_restored) begin
        alarm_active <= alarm_latch;
      end
      if (it.monitoring_ok && !it.circuit_restored && !alarm_latch &&
          it.valid_bits[cda_pkg::VB_BREATH] &&
          !(sequence_seen && last_sequence == it.breath_sequence)) begin
        alarm_active <= latch_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      last_sequence <= '0;
      sequence_seen <= 1'b0;
      leak_run <= '0;
      prior_breath_detected <= 1'b0;
      alarm_latch <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.commit) begin
        out_valid <= 1'b1;
        if (!it.monitoring_ok || it.circuit_restored) begin
          last_sequence <= it.monitoring_ok ? it.breath_sequence : '0;
          sequence_seen <= it.monitoring_ok;
          leak_run <= '0;
          prior_breath_detected <= 1'b0;
          alarm_latch <= 1'b0;
        end else if (!alarm_latch && it.valid_bits[cda_pkg::VB_BREATH] &&
                     !(sequence_seen && last_sequence == it.breath_sequence)) begin
          last_sequence <= it.breath_sequence;
          sequence_seen <= 1'b1;
          leak_run <= run_new;
          prior_breath_detected <= det;
          alarm_latch <= latch_new;
        end
      end
    end
  end
endmodule
`default_nettype wire

[hw/rtl/circuit_disconnect_alarm.sv]
`timescale 1ns / 1ps
`default_nettype none
// Latched patient-circuit disconnect alarm. Each input beat is one breath-monitor snapshot and
// yields exactly one output beat carrying the alarm state after that snapshot. An item
// goes through a multiply step, the bit-serial divider that forms the flow correction, a step
// for the corrected pressure and one for the compliance compare and state update; the last
// step waits while the previous result is in the output register. Items are processed one
// at a time; a finished result waits in the output register while the next item is accepted.
// Registers are pressure_floor at byte address 0 and leak_confirm_breaths at byte address 4;
// the user must write them only while the block is idle; the block does not enforce this.
module circuit_disconnect_alarm (
  input  logic                          clk,
  input  logic                          rst,
  cda_in_if.sink                        in_ch,
  cda_out_if.source                     out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cda_pkg::ADDR_W-1:0]    paddr,
  input  logic [cda_pkg::DATA_W-1:0]    pwdata,
  output logic [cda_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  logic [cda_pkg::FLOOR_W-1:0] pressure_floor;
  logic [cda_pkg::CONF_W-1:0] leak_confirm_breaths;
  cda_pkg::reg_idx_t reg_idx;
  cda_pkg::cmd_t cmd;
  cda_pkg::sts_t sts;
  cda_pkg::item_t item;
  logic in_ready;
  logic out_valid;
  logic alarm_active;

  assign pready = 1'b1;
  assign reg_idx = cda_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pressure_floor <= cda_pkg::FLOOR_RESET;
      leak_confirm_breaths <= cda_pkg::CONF_RESET;
    end else if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        cda_pkg::REG_FLOOR: pressure_floor <= pwdata[cda_pkg::FLOOR_W-1:0];
        cda_pkg::REG_CONFIRM: leak_confirm_breaths <= pwdata[cda_pkg::CONF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      case (reg_idx)
        cda_pkg::REG_FLOOR: prdata = cda_pkg::DATA_W'(pressure_floor);
        cda_pkg::REG_CONFIRM: prdata = cda_pkg::DATA_W'(leak_confirm_breaths);
        default: prdata = '0;
      endcase
    end
  end

  always_comb begin
    item.monitoring_ok = in_ch.monitoring_ok;
    item.circuit_restored = in_ch.circuit_restored;
    item.valid_bits = in_ch.valid_bits;
    item.breath_sequence = in_ch.breath_sequence;
    item.leak_coefficient = in_ch.leak_coefficient;
    item.machine_insp_volume = in_ch.machine_insp_volume;
    item.patient_peak_flow = in_ch.patient_peak_flow;
    item.patient_peak_pressure = in_ch.patient_peak_pressure;
    item.end_insp_flow = in_ch.end_insp_flow;
    item.signed_insp_volume = in_ch.signed_insp_volume;
    item.patient_exp_volume = in_ch.patient_exp_volume;
  end

  assign in_ch.ready = in_ready;
  assign out_ch.valid = out_valid;
  assign out_ch.alarm_active = alarm_active;

  cda_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cda_dp u_dp (
    .clk                  (clk),
    .rst                  (rst),
    .cmd                  (cmd),
    .sts                  (sts),
    .item                 (item),
    .pressure_floor       (pressure_floor),
    .leak_confirm_breaths (leak_confirm_breaths),
    .out_ready            (out_ch.ready),
    .out_valid            (out_valid),
    .alarm_active         (alarm_active)
  );
endmodule
`default_nettype wire

[hw/rtl/cda_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "circuit_disconnect_alarm_assert.svh"
module cda_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_alarm,
  input logic pready
);
  `CDA_ASSERT_NEXT_ALWAYS(a_out_empty_after_reset, clk, rst, !out_valid)
  `CDA_ASSERT_NEXT(a_one_item_at_a_time, clk, rst, in_valid && in_ready, !in_ready)
  `CDA_ASSERT_NEXT(a_result_holds, clk, rst, out_valid && !out_ready, out_valid && $stable(out_alarm))
  `CDA_ASSERT_HOLDS(a_pready_high, clk, rst, pready)
endmodule

bind circuit_disconnect_alarm cda_checker u_cda_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_alarm (out_ch.alarm_active),
  .pready    (pready)
);
`default_nettype wire
